[design/button_debounce_hold_assert.svh]
// assertion macros for the button debounce block
`ifndef BUTTON_DEBOUNCE_HOLD_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_ASSERT_SVH

// same-cycle implication
`define BDH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("button debounce assertion failed");

// next-cycle implication
`define BDH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("button debounce assertion failed");

`endif

[design/bdh_pkg.sv]
`timescale 1ns / 1ps
package bdh_pkg;

	localparam logic [1:0] PH_RELEASED     = 2'd0;
	localparam logic [1:0] PH_PRESS_SEEN   = 2'd1;
	localparam logic [1:0] PH_PRESSED      = 2'd2;
	localparam logic [1:0] PH_RELEASE_SEEN = 2'd3;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_HELD     = 2'd2,
		EV_RELEASED = 2'd3
	} event_t;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD     = 1'b1;

	typedef struct packed {
		logic        raw_level;
		logic [31:0] time_now;
	} in_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic       stable_level;
	} out_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        debounced_pressed;
		logic        hold_done;
		logic [31:0] change_start_time;
		logic [31:0] press_start_time;
	} state_t;

	typedef struct packed {
		logic [31:0] debounce_time;
		logic [31:0] hold_time;
	} cfg_t;

endpackage

[design/button_debounce_hold.sv]
`timescale 1ns / 1ps
// Debounced push button with a one-shot long-press event. Each item is one raw
// sample with a millisecond timestamp and yields exactly one result: an event
// code (none, pressed, held, released) and the debounced level. The block takes
// one item per clock cycle unless out_stall holds the output; each item passes
// through an input register and then the result register, and the button state
// advances by next-state logic as each item moves into the result register.
// Registers debounce_time (index 0) and hold_time (index 1) are written through
// wr_en, wr_index and wr_data; the user must write them only while no item is in flight (not enforced).
`include "button_debounce_hold_assert.svh"

module button_debounce_hold (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [31:0]   wr_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  bdh_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output bdh_pkg::out_t out_data
);

	bdh_pkg::cfg_t   cfg_q;
	bdh_pkg::state_t state_q;
	bdh_pkg::state_t state_nxt;
	bdh_pkg::in_t    item_s1;
	bdh_pkg::out_t   res_nxt;
	logic            valid_s1;
	logic            out_ready;
	logic            advance;
	logic            load;

	assign out_ready = !out_valid || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign load      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				bdh_pkg::REG_DEBOUNCE: cfg_q.debounce_time <= wr_data;
				bdh_pkg::REG_HOLD:     cfg_q.hold_time     <= wr_data;
				default:               cfg_q               <= cfg_q;
			endcase
		end
	end

	bdh_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= res_nxt;
		end
	end

	// stable level always agrees with the phase
	`BDH_ASSERT_NOW(a_level_phase, 1'b1, state_q.debounced_pressed ==
		(state_q.phase == bdh_pkg::PH_PRESSED || state_q.phase == bdh_pkg::PH_RELEASE_SEEN))
	// a press event reports the pressed level, a release the released level
	`BDH_ASSERT_NOW(a_event_level, out_valid && (out_data.event_code == bdh_pkg::EV_PRESSED ||
		out_data.event_code == bdh_pkg::EV_RELEASED), out_data.stable_level ==
		(out_data.event_code == bdh_pkg::EV_PRESSED))
	// a stalled input means a full pipe
	`BDH_ASSERT_NEXT(a_stall_hold, in_stall && out_stall, valid_s1 && out_valid &&
		$stable(state_q))

endmodule

[design/bdh_step.sv]
`timescale 1ns / 1ps
module bdh_step (
	input  bdh_pkg::state_t cur,
	input  bdh_pkg::in_t    item,
	input  bdh_pkg::cfg_t   cfg,
	output bdh_pkg::state_t nxt,
	output bdh_pkg::out_t   res
);

	logic [31:0] change_elapsed;
	logic [31:0] press_elapsed;
	logic        debounce_met;
	logic        hold_met;
	logic [1:0]  ev;

	assign change_elapsed = item.time_now - cur.change_start_time;
	assign press_elapsed  = item.time_now - cur.press_start_time;
	assign debounce_met   = change_elapsed >= cfg.debounce_time;
	assign hold_met       = (cfg.hold_time != 32'd0) && (press_elapsed >= cfg.hold_time);

	always_comb begin
		nxt = cur;
		ev  = bdh_pkg::EV_NONE;
		unique case (cur.phase)
			bdh_pkg::PH_RELEASED: begin
				if (item.raw_level) begin
					nxt.phase             = bdh_pkg::PH_PRESS_SEEN;
					nxt.change_start_time = item.time_now;
				end
			end
			bdh_pkg::PH_PRESS_SEEN: begin
				if (!item.raw_level) begin
					nxt.phase = bdh_pkg::PH_RELEASED;
				end else if (debounce_met) begin
					nxt.phase             = bdh_pkg::PH_PRESSED;
					nxt.debounced_pressed = 1'b1;
					nxt.hold_done         = 1'b0;
					nxt.press_start_time  = item.time_now;
					ev                    = bdh_pkg::EV_PRESSED;
				end
			end
			bdh_pkg::PH_PRESSED: begin
				if (!item.raw_level) begin
					nxt.phase             = bdh_pkg::PH_RELEASE_SEEN;
					nxt.change_start_time = item.time_now;
				end else if (!cur.hold_done && hold_met) begin
					nxt.hold_done = 1'b1;
					ev            = bdh_pkg::EV_HELD;
				end
			end
			bdh_pkg::PH_RELEASE_SEEN: begin
				if (item.raw_level) begin
					nxt.phase = bdh_pkg::PH_PRESSED;
				end else if (debounce_met) begin
					nxt.phase             = bdh_pkg::PH_RELEASED;
					nxt.debounced_pressed = 1'b0;
					ev                    = bdh_pkg::EV_RELEASED;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		res.event_code   = ev;
		res.stable_level = nxt.debounced_pressed;
	end

endmodule
